// ===== design/ufoq_pkg.sv =====
// ----------------------------------------------------------------------------
// ufoq_pkg
// Types and constants of the ultrasonic frame obstacle qualifier.
// ----------------------------------------------------------------------------
package ufoq_pkg;

  localparam int unsigned NearW       = 7;
  localparam int unsigned CountW      = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned FirstDist   = 4;

  localparam logic [7:0] HdrFirst     = 8'h76;
  localparam logic [7:0] HdrSecond    = 8'h00;

  localparam logic [7:0]        RstNearThreshold = 8'd15;
  localparam logic [CountW-1:0] RstConfirmCount  = 3'd4;
  localparam logic [NearW-1:0]  RstLeftMask      = 7'h03;
  localparam logic [NearW-1:0]  RstRightMask     = 7'h60;
  localparam logic [NearW-1:0]  RstFrontMask     = 7'h1C;
  localparam logic [CountW-1:0] RstLeftCount     = 3'd1;
  localparam logic [CountW-1:0] RstRightCount    = 3'd1;
  localparam logic [CountW-1:0] RstFrontCount    = 3'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEAR_THRESHOLD = 3'd0,
    CFG_CONFIRM_COUNT  = 3'd1,
    CFG_LEFT_MASK      = 3'd2,
    CFG_RIGHT_MASK     = 3'd3,
    CFG_FRONT_MASK     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } ufoq_in_t;

  typedef struct packed {
    logic             frame_done;
    logic             checksum_ok;
    logic [NearW-1:0] near_bits;
    logic             left_event;
    logic             right_event;
    logic             front_event;
    logic             stop_request;
  } ufoq_out_t;

endpackage

// ===== design/ufoq_stream_if.sv =====
// ----------------------------------------------------------------------------
// ufoq_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ufoq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ultrasonic_frame_obstacle_qualifier.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_frame_obstacle_qualifier
// Frames sensor packets, checks their sum and qualifies obstacles per side.
// ----------------------------------------------------------------------------
// The result item of an accepted byte is registered, offered the cycle after.
// Throughput: one byte per cycle while results are taken; the frame state
// register is updated once per accepted byte and the result register drains
// while the next is taken. Reset: frame state hunts for the header, counters
// and settings take their power-on values, no result item is pending.
module ultrasonic_frame_obstacle_qualifier
  import ufoq_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 17,
  parameter int unsigned CHANNELS    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ufoq_stream_if.sink         rx_i,
  ufoq_stream_if.source       res_o
);

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

  logic [7:0]        near_threshold_q;
  logic [CountW-1:0] confirm_count_q;
  logic [NearW-1:0]  left_mask_q, right_mask_q, front_mask_q;

  logic [PosW-1:0]   pos_q, pos_d;
  logic [7:0]        sum_q, sum_d;
  logic [NearW-1:0]  near_q, near_d;
  logic [CountW-1:0] left_cnt_q, left_cnt_d;
  logic [CountW-1:0] right_cnt_q, right_cnt_d;
  logic [CountW-1:0] front_cnt_q, front_cnt_d;

  logic              out_valid_q;
  ufoq_out_t         out_q, out_d;
  logic              accept;
  logic [7:0]        b;
  logic [NearW-1:0]  byte_near;

  assign rx_i.ready  = !out_valid_q || res_o.ready;
  assign accept      = rx_i.valid && rx_i.ready;
  assign b           = rx_i.data.rx_byte;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_threshold_q <= RstNearThreshold;
      confirm_count_q  <= RstConfirmCount;
      left_mask_q      <= RstLeftMask;
      right_mask_q     <= RstRightMask;
      front_mask_q     <= RstFrontMask;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAR_THRESHOLD: near_threshold_q <= cfg_data_i;
        CFG_CONFIRM_COUNT:  confirm_count_q  <= cfg_data_i[CountW-1:0];
        CFG_LEFT_MASK:      left_mask_q      <= cfg_data_i[NearW-1:0];
        CFG_RIGHT_MASK:     right_mask_q     <= cfg_data_i[NearW-1:0];
        CFG_FRONT_MASK:     front_mask_q     <= cfg_data_i[NearW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NearW; c++) begin
      byte_near[c] = (c < CHANNELS) && (32'(pos_q) == FirstDist + 32'(c))
                     && (b < near_threshold_q);
    end
  end

  function automatic logic [CountW:0] qualify(logic [CountW-1:0] cnt,
                                              logic [NearW-1:0]  mask,
                                              logic [NearW-1:0]  nb,
                                              logic [CountW-1:0] confirm);
    logic hit;
    logic fire;
    hit  = |(nb & mask);
    fire = hit && (cnt == confirm);
    if (fire) begin
      return {1'b1, {CountW{1'b0}}};
    end else if (hit) begin
      return {1'b0, cnt + CountW'(1)};
    end
    return {1'b0, cnt};
  endfunction

  always_comb begin
    logic [CountW:0] lq, rq, fq;
    pos_d       = pos_q;
    sum_d       = sum_q;
    near_d      = near_q;
    left_cnt_d  = left_cnt_q;
    right_cnt_d = right_cnt_q;
    front_cnt_d = front_cnt_q;
    out_d       = '0;
    lq = qualify(left_cnt_q,  left_mask_q,  near_q, confirm_count_q);
    rq = qualify(right_cnt_q, right_mask_q, near_q, confirm_count_q);
    fq = qualify(front_cnt_q, front_mask_q, near_q, confirm_count_q);
    if (pos_q == PosW'(0)) begin
      if (b == HdrFirst) pos_d = PosW'(1);
    end else if (pos_q == PosW'(1)) begin
      if (b == HdrSecond) begin
        pos_d  = PosW'(2);
        sum_d  = '0;
        near_d = '0;
      end else if (b != HdrFirst) begin
        pos_d = '0;
      end
    end else if (pos_q >= LastPos) begin
      out_d.frame_done  = 1'b1;
      out_d.checksum_ok = (b == sum_q);
      out_d.near_bits   = near_q;
      if (b == sum_q) begin
        out_d.left_event  = lq[CountW];
        out_d.right_event = rq[CountW];
        out_d.front_event = fq[CountW];
        left_cnt_d        = lq[CountW-1:0];
        right_cnt_d       = rq[CountW-1:0];
        front_cnt_d       = fq[CountW-1:0];
      end
      out_d.stop_request = out_d.left_event | out_d.right_event | out_d.front_event;
      pos_d  = '0;
      sum_d  = '0;
      near_d = '0;
    end else begin
      sum_d  = sum_q + b;
      near_d = near_q | byte_near;
      pos_d  = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      near_q      <= '0;
      left_cnt_q  <= RstLeftCount;
      right_cnt_q <= RstRightCount;
      front_cnt_q <= RstFrontCount;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q       <= pos_d;
        sum_q       <= sum_d;
        near_q      <= near_d;
        left_cnt_q  <= left_cnt_d;
        right_cnt_q <= right_cnt_d;
        front_cnt_q <= front_cnt_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("frame position past last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.stop_request ==
                     (out_q.left_event | out_q.right_event | out_q.front_event)))
    else $error("stop request does not match events");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.left_event || out_q.right_event || out_q.front_event)
      |-> out_q.checksum_ok)
    else $error("event on a frame with a bad sum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.frame_done |-> (out_q.near_bits == '0) && !out_q.checksum_ok)
    else $error("frame fields set outside frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (pos_q >= LastPos) && (b == sum_q) && (|(near_q & left_mask_q))
      && (left_cnt_q == confirm_count_q) |=> (left_cnt_q == '0))
    else $error("left counter not cleared after event");

endmodule

// ===== tb/ultrasonic_frame_obstacle_qualifier_tb.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_frame_obstacle_qualifier_tb
// Self-checking bench for the ultrasonic frame obstacle qualifier. Byte
// streams made of well-formed sensor frames, bad checksums, broken headers
// and noise are sent over the input channel. A predictor of the framer, the
// checksum, the near detection and the three side counters computes the
// report for every accepted byte. A checker compares each report item field
// by field. Both channel sides idle and stall at random, and the settings
// are swept through several phases, the extremes among them.
// ----------------------------------------------------------------------------
module ultrasonic_frame_obstacle_qualifier_tb;
  import ufoq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameBytes = 17;
  localparam int unsigned Channels   = 7;
  localparam int unsigned CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ufoq_stream_if #(.T(ufoq_in_t))  rx_if ();
  ufoq_stream_if #(.T(ufoq_out_t)) res_if ();

  ultrasonic_frame_obstacle_qualifier #(
    .FRAME_BYTES(FrameBytes),
    .CHANNELS   (Channels)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .rx_i      (rx_if),
    .res_o     (res_if)
  );

  // predictor state and settings
  logic [4:0]        frame_pos;
  logic [7:0]        frame_sum;
  logic [NearW-1:0]  near_seen;
  logic [CountW-1:0] left_cnt;
  logic [CountW-1:0] right_cnt;
  logic [CountW-1:0] front_cnt;
  logic [7:0]        near_thr;
  logic [CountW-1:0] confirm_val;
  logic [NearW-1:0]  left_sel;
  logic [NearW-1:0]  right_sel;
  logic [NearW-1:0]  front_sel;

  ufoq_out_t   pending_reports[$];
  ufoq_out_t   got_report;
  ufoq_out_t   want_report;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  bit          offering   = 1'b0;
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;
  int unsigned hold_len   = 1;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[ultrasonic_frame_obstacle_qualifier] ERROR");
      $finish;
    end
  end

  function automatic logic side_update(inout logic [CountW-1:0] cnt,
                                       input logic [NearW-1:0] sel,
                                       input logic [NearW-1:0] nb);
    if ((nb & sel) == '0) return 1'b0;
    if (cnt == confirm_val) begin
      cnt = '0;
      return 1'b1;
    end
    cnt = cnt + 1'b1;
    return 1'b0;
  endfunction

  function automatic ufoq_out_t predict_report(logic [7:0] b);
    ufoq_out_t   r;
    int unsigned ch;
    r = '0;
    if (frame_pos == 0) begin
      if (b == HdrFirst) frame_pos = 5'd1;
    end else if (frame_pos == 1) begin
      if (b == HdrSecond) begin
        frame_pos = 5'd2;
        frame_sum = '0;
        near_seen = '0;
      end else if (b != HdrFirst) begin
        frame_pos = 5'd0;
      end
    end else if (frame_pos >= FrameBytes - 1) begin
      r.frame_done  = 1'b1;
      r.checksum_ok = (b == frame_sum);
      r.near_bits   = near_seen;
      if (r.checksum_ok) begin
        r.left_event  = side_update(left_cnt, left_sel, near_seen);
        r.right_event = side_update(right_cnt, right_sel, near_seen);
        r.front_event = side_update(front_cnt, front_sel, near_seen);
      end
      r.stop_request = r.left_event | r.right_event | r.front_event;
      frame_pos = 5'd0;
      frame_sum = '0;
      near_seen = '0;
    end else begin
      frame_sum = frame_sum + b;
      if (frame_pos >= FirstDist && frame_pos < FirstDist + Channels) begin
        ch = frame_pos - FirstDist;
        if (ch < NearW && b < near_thr) near_seen[ch] = 1'b1;
      end
      frame_pos = frame_pos + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] echo_byte(int unsigned near_pct);
    if (near_thr != 0 && $urandom_range(0, 99) < near_pct) begin
      return 8'($urandom_range(0, near_thr - 1));
    end
    return 8'($urandom_range(near_thr, 255));
  endfunction

  task automatic rx_idle();
    if (offering) begin
      rx_if.valid <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        if (offering) begin
          rx_if.valid <= 1'b0;
          offering = 1'b0;
        end
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_if.valid        <= 1'b1;
    rx_if.data.rx_byte <= b;
    offering = 1'b1;
    do @(posedge clk_i); while (!rx_if.ready);
    pending_reports.push_back(predict_report(b));
  endtask

  task automatic send_frame(int unsigned near_pct, bit bad_sum);
    logic [7:0] fb[FrameBytes];
    logic [7:0] csum;
    fb[0] = HdrFirst;
    fb[1] = HdrSecond;
    csum  = '0;
    for (int i = 2; i < FrameBytes - 1; i++) begin
      if (i >= FirstDist && i < FirstDist + Channels) fb[i] = echo_byte(near_pct);
      else fb[i] = 8'($urandom_range(0, 255));
      csum = csum + fb[i];
    end
    fb[FrameBytes-1] = bad_sum ? csum + 8'($urandom_range(1, 255)) : csum;
    for (int i = 0; i < FrameBytes; i++) send_byte(fb[i]);
  endtask

  task automatic wait_drain();
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] thr, logic [CountW-1:0] cc,
                            logic [NearW-1:0] l, logic [NearW-1:0] r,
                            logic [NearW-1:0] f);
    logic [CfgDataW-1:0] vals[5];
    vals = '{thr, CfgDataW'(cc), CfgDataW'(l), CfgDataW'(r), CfgDataW'(f)};
    rx_idle();
    wait_drain();
    @(posedge clk_i);
    for (int k = 0; k < 5; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(k);
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    near_thr    = thr;
    confirm_val = cc;
    left_sel    = l;
    right_sel   = r;
    front_sel   = f;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_report = res_if.data;
      if (pending_reports.size() == 0) begin
        $error("report item with none expected");
        error_count++;
      end else begin
        want_report = pending_reports.pop_front();
        check_field("frame_done", want_report.frame_done, got_report.frame_done);
        check_field("checksum_ok", want_report.checksum_ok, got_report.checksum_ok);
        check_field("near_bits", want_report.near_bits, got_report.near_bits);
        check_field("left_event", want_report.left_event, got_report.left_event);
        check_field("right_event", want_report.right_event, got_report.right_event);
        check_field("front_event", want_report.front_event, got_report.front_event);
        check_field("stop_request", want_report.stop_request, got_report.stop_request);
      end
    end
  end

  initial begin
    int unsigned seg_mode;
    int unsigned seg_len;
    res_if.ready <= 1'b0;
    forever begin
      seg_mode = $urandom_range(0, 3);
      seg_len  = $urandom_range(8, 64);
      repeat (seg_len) begin
        @(posedge clk_i);
        if (hold_req) begin
          hold_req = 1'b0;
          res_if.ready <= 1'b0;
          repeat (hold_len) @(posedge clk_i);
        end
        case (seg_mode)
          0: begin
            res_if.ready <= 1'b1;
          end
          1: begin
            res_if.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            res_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            res_if.ready <= ~res_if.ready;
          end
        endcase
      end
    end
  end

  task automatic test_reset_settings();
    repeat (5) send_frame(100, 1'b0);
  endtask

  task automatic test_header_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HdrFirst);
    send_byte(8'h55);
    send_byte(HdrFirst);
    send_frame(50, 1'b0);
  endtask

  task automatic test_checksum();
    send_frame(60, 1'b0);
    send_frame(60, 1'b1);
  endtask

  task automatic test_counter_wrap();
    set_config(8'd255, 3'd7, 7'h7F, 7'h7F, 7'h7F);
    repeat (3) send_frame(100, 1'b0);
    set_config(8'd255, 3'd1, 7'h7F, 7'h7F, 7'h7F);
    repeat (8) send_frame(100, 1'b0);
  endtask

  task automatic test_backpressure();
    set_config(8'd128, 3'd2, 7'h07, 7'h70, 7'h08);
    gaps_on  = 1'b0;
    hold_len = 300;
    hold_req = 1'b1;
    repeat (3) send_frame(70, 1'b0);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_frame(70, 1'b0);
    rx_idle();
    wait_drain();
    send_frame(70, 1'b0);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          set_config(8'd255, 3'd7, 7'h7F, 7'h7F, 7'h7F);
        end
        1: begin
          set_config(8'd0, 3'd1, 7'h00, 7'h00, 7'h00);
        end
        default: begin
          set_config(8'($urandom_range(0, 255)), 3'($urandom_range(1, 7)),
                     7'($urandom), 7'($urandom), 7'($urandom));
        end
      endcase
      gaps_on = (phase % 3 != 2);
      sent = 0;
      while (sent < 12) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          send_frame($urandom_range(20, 90), 1'b0);
          sent += FrameBytes;
        end else if (kind < 85) begin
          send_frame($urandom_range(20, 90), 1'b1);
          sent += FrameBytes;
        end else if (kind < 93) begin
          send_byte(HdrFirst);
          send_byte($urandom_range(0, 1) ? HdrSecond : HdrFirst);
          n = $urandom_range(0, 10);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
          sent += n + 2;
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
          sent += n;
        end
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_NEAR_THRESHOLD;
    cfg_data_i         <= '0;
    rx_if.valid        <= 1'b0;
    rx_if.data.rx_byte <= '0;
    frame_pos   = '0;
    frame_sum   = '0;
    near_seen   = '0;
    left_cnt    = RstLeftCount;
    right_cnt   = RstRightCount;
    front_cnt   = RstFrontCount;
    near_thr    = RstNearThreshold;
    confirm_val = RstConfirmCount;
    left_sel    = RstLeftMask;
    right_sel   = RstRightMask;
    front_sel   = RstFrontMask;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_header_hunting();
    test_checksum();
    test_counter_wrap();
    test_backpressure();
    test_drain_pause();
    test_random();

    rx_idle();
    wait_drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("[ultrasonic_frame_obstacle_qualifier] OK");
    end else begin
      $display("[ultrasonic_frame_obstacle_qualifier] ERROR");
    end
    $finish;
  end

endmodule
